// File: sv/paired_byte_color_table_write_defines.svh
// ----------------------------------------------------------------------------
// Paired byte color table write - assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PAIRED_BYTE_COLOR_TABLE_WRITE_DEFINES_SVH
`define PAIRED_BYTE_COLOR_TABLE_WRITE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PBCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pbct check failed");

// next-cycle implication, disabled while reset is asserted
`define PBCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pbct check failed");

`endif

// File: sv/pbct_pkg.sv
// ----------------------------------------------------------------------------
// pbct_pkg
// Types, sizes and codes shared by the color table write port modules.
// ----------------------------------------------------------------------------
package pbct_pkg;

    // table geometry
    localparam int TABLE_ENTRIES  = 512;
    localparam int LOOKUP_ENTRIES = 32;
    localparam int TBL_AW         = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W         = $clog2(LOOKUP_ENTRIES);
    localparam int CLEAR_LEN      = (TABLE_ENTRIES > LOOKUP_ENTRIES) ?
                                    TABLE_ENTRIES : LOOKUP_ENTRIES;
    localparam int CLR_W          = $clog2(CLEAR_LEN);

    // fixed field widths
    localparam int INDEX_W = 10;
    localparam int EIDX_W  = 9;
    localparam int ENTRY_W = 15;
    localparam int DER_W   = 8;
    localparam int COMB_W  = 16;

    // action codes
    localparam logic [1:0] ACT_DATA   = 2'd0;
    localparam logic [1:0] ACT_INDEX  = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         data;
        logic [INDEX_W-1:0] new_index;
        logic [4:0]         lookup_slot;
        logic               frame_stale;
    } t_request;

    typedef struct packed {
        logic               accepted;
        logic               changed;
        logic               flush_request;
        logic               high_half;
        logic [EIDX_W-1:0]  entry_index;
        logic [ENTRY_W-1:0] entry_value;
        logic [COMB_W-1:0]  combined_value;
        logic [INDEX_W-1:0] index_after;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic calc;
        logic commit;
        logic simple;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic data_hit;
        logic clear_last;
    } t_dp_status;

endpackage

// File: sv/pbct_ram.sv
// ----------------------------------------------------------------------------
// pbct_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module pbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/pbct_ctrl.sv
// ----------------------------------------------------------------------------
// pbct_ctrl
// Sequencer: clearing pass after reset, then read / compute / commit for
// each in-range data byte write; other requests finish straight from idle.
// ----------------------------------------------------------------------------
module pbct_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  pbct_pkg::t_dp_status i_status,
    output pbct_pkg::t_dp_cmd   o_cmd,
    output logic                busy
);
    import pbct_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_CALC  = 4'b0100,
        ST_WRITE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start && i_status.data_hit) n_state = ST_CALC;
            end
            ST_CALC:  n_state = ST_WRITE;
            ST_WRITE: n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    always_comb begin
        o_cmd.clear   = (r_state == ST_CLEAR);
        o_cmd.capture = (r_state == ST_IDLE) && start && i_status.data_hit;
        o_cmd.simple  = (r_state == ST_IDLE) && start && !i_status.data_hit;
        o_cmd.calc    = (r_state == ST_CALC);
        o_cmd.commit  = (r_state == ST_WRITE);
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// File: sv/pbct_datapath.sv
// ----------------------------------------------------------------------------
// pbct_datapath
// Index and phase registers, entry and derived stores, lookup table and the
// result register.
// ----------------------------------------------------------------------------
module pbct_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pbct_pkg::t_dp_cmd    i_cmd,
    input  pbct_pkg::t_request   i_req,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    output pbct_pkg::t_dp_status o_status,
    output logic                 o_done,
    output pbct_pkg::t_result    o_res
);
    import pbct_pkg::*;

    // control registers
    logic               r_phase,       n_phase;
    logic [INDEX_W-1:0] r_write_index, n_write_index;
    logic               r_derived_enable;
    logic [CLR_W-1:0]   r_clr_cnt;
    logic               r_done;
    t_result            r_res,         n_res;

    // per-request payload registers
    logic [7:0]         r_data;
    logic               r_stale;
    logic [ENTRY_W-1:0] r_value,   n_value;
    logic               r_changed, n_changed;
    logic [DER_W-1:0]   r_lohi;

    // memory ports
    logic [TBL_AW-1:0]  tbl_addr, tbl_waddr;
    logic [ENTRY_W-1:0] entry_rdata, entry_wdata;
    logic [DER_W-1:0]   low_rdata, low_wdata;
    logic [DER_W-1:0]   high_rdata, high_wdata;
    logic [COMB_W-1:0]  comb_rdata, comb_wdata, comb_new;
    logic               entry_we, low_we, high_we, comb_we;
    logic [DER_W-1:0]   luta_rdata, lutb_rdata;
    logic [SLOT_W-1:0]  luta_raddr, lutb_raddr, lut_waddr;
    logic [DER_W-1:0]   lut_wdata;
    logic               lut_we;
    logic               upd;
    logic [DER_W-1:0]   lo_w, hi_w;

    assign tbl_addr = r_write_index[TBL_AW-1:0];

    // status to the controller
    assign o_status.data_hit   = (i_req.action == ACT_DATA) &&
        ({1'b0, r_write_index} < (INDEX_W + 1)'(TABLE_ENTRIES));
    assign o_status.clear_last = (r_clr_cnt == CLR_W'(CLEAR_LEN - 1));

    // compute step: merge the written half into the current entry
    always_comb begin
        if (!r_phase) begin
            n_value   = {entry_rdata[14:8], r_data};
            n_changed = (entry_rdata[7:0] != r_data);
        end else begin
            n_value   = {r_data[6:0], entry_rdata[7:0]};
            n_changed = (entry_rdata[14:8] != r_data[6:0]);
        end
    end

    // lookup addresses: low/high field from the byte, mid field from the merge
    assign luta_raddr = r_phase ? i_req.data[6:2] : i_req.data[4:0];
    assign lutb_raddr = n_value[9:5];

    // commit step: derived words
    assign upd  = r_changed && r_derived_enable;
    assign lo_w = r_phase ? low_rdata : r_lohi;
    assign hi_w = r_phase ? r_lohi    : high_rdata;
    assign comb_new = COMB_W'(lo_w) | (COMB_W'(lutb_rdata) << 5) | (COMB_W'(hi_w) << 10);

    // store writes: clearing pass, commit or lookup load
    always_comb begin
        tbl_waddr   = i_cmd.clear ? r_clr_cnt[TBL_AW-1:0] : tbl_addr;
        entry_wdata = i_cmd.clear ? '0 : r_value;
        low_wdata   = i_cmd.clear ? '0 : r_lohi;
        high_wdata  = i_cmd.clear ? '0 : r_lohi;
        comb_wdata  = i_cmd.clear ? '0 : comb_new;
        entry_we    = i_cmd.clear ? ({1'b0, r_clr_cnt} < (CLR_W + 1)'(TABLE_ENTRIES))
                                  : (i_cmd.commit && r_changed);
        low_we      = i_cmd.clear ? entry_we : (i_cmd.commit && upd && !r_phase);
        high_we     = i_cmd.clear ? entry_we : (i_cmd.commit && upd && r_phase);
        comb_we     = i_cmd.clear ? entry_we : (i_cmd.commit && upd);
        lut_waddr   = i_cmd.clear ? r_clr_cnt[SLOT_W-1:0] : i_req.lookup_slot;
        lut_wdata   = i_cmd.clear ? '0 : i_req.data;
        lut_we      = i_cmd.clear ? ({1'b0, r_clr_cnt} < (CLR_W + 1)'(LOOKUP_ENTRIES))
                                  : (i_cmd.simple && (i_req.action == ACT_LOOKUP));
    end

    // index, phase and result
    always_comb begin
        n_phase       = r_phase;
        n_write_index = r_write_index;
        n_res         = '0;
        if (i_cmd.simple) begin
            if (i_req.action == ACT_INDEX) begin
                n_write_index = i_req.new_index;
                n_phase       = 1'b0;
            end
            n_res.index_after = n_write_index;
        end else if (i_cmd.commit) begin
            n_phase = !r_phase;
            if (r_phase) n_write_index = r_write_index + 1'b1;
            n_res.accepted       = 1'b1;
            n_res.changed        = r_changed;
            n_res.flush_request  = upd && r_stale;
            n_res.high_half      = r_phase;
            n_res.entry_index    = r_write_index[EIDX_W-1:0];
            n_res.entry_value    = r_value;
            n_res.combined_value = upd ? comb_new : comb_rdata;
            n_res.index_after    = n_write_index;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= 1'b0;
            r_write_index    <= '0;
            r_derived_enable <= 1'b0;
            r_clr_cnt        <= '0;
            r_done           <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_write_index <= n_write_index;
            r_done        <= i_cmd.simple || i_cmd.commit;
            if (i_cfg_we) r_derived_enable <= i_cfg_wdata;
            if (i_cmd.clear) r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_cmd.capture) begin
            r_data  <= i_req.data;
            r_stale <= i_req.frame_stale;
        end
        if (i_cmd.calc) begin
            r_value   <= n_value;
            r_changed <= n_changed;
            r_lohi    <= luta_rdata;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    // stores; the mid word is never read back, so only low, high and
    // combined words are kept
    pbct_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_entry (
        .i_clk(i_clk), .i_we(entry_we), .i_waddr(tbl_waddr), .i_wdata(entry_wdata),
        .i_raddr(tbl_addr), .o_rdata(entry_rdata)
    );

    pbct_ram #(.WIDTH(DER_W), .DEPTH(TABLE_ENTRIES)) u_low (
        .i_clk(i_clk), .i_we(low_we), .i_waddr(tbl_waddr), .i_wdata(low_wdata),
        .i_raddr(tbl_addr), .o_rdata(low_rdata)
    );

    pbct_ram #(.WIDTH(DER_W), .DEPTH(TABLE_ENTRIES)) u_high (
        .i_clk(i_clk), .i_we(high_we), .i_waddr(tbl_waddr), .i_wdata(high_wdata),
        .i_raddr(tbl_addr), .o_rdata(high_rdata)
    );

    pbct_ram #(.WIDTH(COMB_W), .DEPTH(TABLE_ENTRIES)) u_comb (
        .i_clk(i_clk), .i_we(comb_we), .i_waddr(tbl_waddr), .i_wdata(comb_wdata),
        .i_raddr(tbl_addr), .o_rdata(comb_rdata)
    );

    // lookup table, duplicated for its two read addresses
    pbct_ram #(.WIDTH(DER_W), .DEPTH(LOOKUP_ENTRIES)) u_lut_a (
        .i_clk(i_clk), .i_we(lut_we), .i_waddr(lut_waddr), .i_wdata(lut_wdata),
        .i_raddr(luta_raddr), .o_rdata(luta_rdata)
    );

    pbct_ram #(.WIDTH(DER_W), .DEPTH(LOOKUP_ENTRIES)) u_lut_b (
        .i_clk(i_clk), .i_we(lut_we), .i_waddr(lut_waddr), .i_wdata(lut_wdata),
        .i_raddr(lutb_raddr), .o_rdata(lutb_rdata)
    );

endmodule

// File: sv/paired_byte_color_table_write.sv
// ----------------------------------------------------------------------------
// paired_byte_color_table_write
// Byte-wide write port into a 15-bit color table with derived lookup words.
// ----------------------------------------------------------------------------
// Usage:
//   A request (i_req) is taken at a rising edge with start high and busy low.
//   Every request produces one result on o_res, marked by o_done for exactly
//   one cycle; the receiver cannot stall it.
//   Set-index, lookup-load, unknown and out-of-range data requests finish at
//   the accepting edge: o_done is high the next cycle and busy stays low, so
//   one such request can be taken every cycle.
//   An in-range data byte write does a read-modify-write of the entry and
//   derived stores: registered memory read at the accepting edge, merge plus
//   mid-field lookup read in the CALC state, store writes in the WRITE state,
//   which also registers the result and o_done. busy is high through CALC and
//   WRITE, so the next request is taken only once the write is done.
//   derived_enable is written through i_cfg_we / i_cfg_wdata at any edge.
//   After reset a clearing pass zeros all stores, one entry per cycle, over
//   the 512-entry table depth; busy is high throughout.
// ----------------------------------------------------------------------------
module paired_byte_color_table_write (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pbct_pkg::t_request i_req,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    output logic               o_done,
    output pbct_pkg::t_result  o_res
);
    import pbct_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    pbct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    pbct_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_status    (status),
        .o_done      (o_done),
        .o_res       (o_res)
    );

endmodule

// File: sv/pbct_checker.sv
// ----------------------------------------------------------------------------
// pbct_checker
// Port-level checks on results of the color table write port.
// ----------------------------------------------------------------------------
`include "paired_byte_color_table_write_defines.svh"

module pbct_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input pbct_pkg::t_request i_req,
    input logic               o_done,
    input pbct_pkg::t_result  o_res
);
    import pbct_pkg::*;

    logic req_take;
    logic idx_load;
    logic rej_clean;
    logic flush_ok;

    // request taken, index load taken, clean rejected result, valid flush
    assign req_take  = start && !busy;
    assign idx_load  = req_take && (i_req.action == ACT_INDEX);
    assign rej_clean = !o_res.changed && !o_res.flush_request && !o_res.high_half &&
                       (o_res.entry_index == '0) && (o_res.entry_value == '0) &&
                       (o_res.combined_value == '0);
    assign flush_ok  = o_res.changed && o_res.accepted;

    // requests other than data writes finish right away
    `PBCT_ASSERT_NEXT(a_quick_done, i_clk, i_rst_n, req_take && (i_req.action != ACT_DATA), o_done)

    // set index shows up in the next result
    `PBCT_ASSERT_NEXT(a_index_load, i_clk, i_rst_n, idx_load, o_res.index_after == $past(i_req.new_index))

    // a rejected request carries only the index
    `PBCT_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n, o_done && !o_res.accepted, rej_clean)

    // flush only on a real change of an accepted write
    `PBCT_ASSERT_NOW(a_flush_chg, i_clk, i_rst_n, o_done && o_res.flush_request, flush_ok)

endmodule

bind paired_byte_color_table_write pbct_checker u_pbct_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_res   (o_res)
);
